// ----- rtl/core/sync_frame_deframer_crc16_assert.svh -----
// assertion helpers used by sync_frame_deframer_crc16.sv
`ifndef SYNC_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define SYNC_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SFDC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sfdc_pkg.sv -----
`timescale 1ns / 1ps

package sfdc_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CNT_W       = 9;
   localparam int LEN_W       = 16;

   localparam logic REG_SYNC_FIRST  = 1'b0;
   localparam logic REG_SYNC_SECOND = 1'b1;

   localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD = 16'd256;
   localparam logic [CNT_W-1:0] HDR_LAST    = 9'd12;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_PAYLOAD  = 3'd1;
   localparam logic [2:0] ST_READY    = 3'd2;
   localparam logic [2:0] ST_CRCERR   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT_FIRST,
      PH_HUNT_SECOND,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  payload_byte;
      logic [7:0]  version;
      logic [7:0]  flags;
      logic [7:0]  packet_type;
      logic [8:0]  payload_length;
      logic [31:0] sequence_res;
      logic [31:0] timestamp_ms;
      logic [15:0] received_crc;
   } rsp_type;

   // crc-16 ccitt, msb first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/sfdc_frame_fsm.sv -----
`timescale 1ns / 1ps

module sfdc_frame_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  sfdc_pkg::cfg_type cfg,
   output sfdc_pkg::rsp_type result
);
   import sfdc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        version_ff, version_in;
   logic [7:0]        flags_ff, flags_in;
   logic [7:0]        type_ff, type_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [31:0]       sequence_ff, sequence_in;
   logic [31:0]       timestamp_ff, timestamp_in;
   logic [7:0]        crc_low_ff, crc_low_in;

   logic [15:0]      crc_upd;
   logic [LEN_W-1:0] count_wide;
   logic [15:0]      rx_crc;
   logic             hdr_last;
   logic             too_long;

   assign crc_upd    = crc16_byte(crc_ff, rx_byte);
   assign count_wide = {{(LEN_W-CNT_W){1'b0}}, count_ff};
   assign rx_crc     = {rx_byte, crc_low_ff};
   assign hdr_last   = (count_ff == HDR_LAST);
   assign too_long   = (length_ff > MAX_PAYLOAD);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      version_in   = version_ff;
      flags_in     = flags_ff;
      type_in      = type_ff;
      length_in    = length_ff;
      sequence_in  = sequence_ff;
      timestamp_in = timestamp_ff;
      crc_low_in   = crc_low_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT_FIRST: begin
               if (rx_byte == cfg.sync_first) phase_in = PH_HUNT_SECOND;
            end
            PH_HUNT_SECOND: begin
               if (rx_byte == cfg.sync_second) begin
                  phase_in = PH_HEADER;
                  count_in = '0;
                  crc_in   = CRC_INIT;
               end else if (rx_byte != cfg.sync_first) begin
                  phase_in = PH_HUNT_FIRST;
               end
            end
            PH_HEADER: begin
               crc_in   = crc_upd;
               count_in = count_ff + 1'b1;
               case (count_ff[3:0])
                  4'd0:  version_in = rx_byte;
                  4'd1:  flags_in = rx_byte;
                  4'd2:  type_in = rx_byte;
                  4'd3:  length_in[7:0] = rx_byte;
                  4'd4:  length_in[15:8] = rx_byte;
                  4'd5:  sequence_in[7:0] = rx_byte;
                  4'd6:  sequence_in[15:8] = rx_byte;
                  4'd7:  sequence_in[23:16] = rx_byte;
                  4'd8:  sequence_in[31:24] = rx_byte;
                  4'd9:  timestamp_in[7:0] = rx_byte;
                  4'd10: timestamp_in[15:8] = rx_byte;
                  4'd11: timestamp_in[23:16] = rx_byte;
                  4'd12: timestamp_in[31:24] = rx_byte;
                  default: ;
               endcase
               if (hdr_last) begin
                  count_in = '0;
                  phase_in = PH_BODY;
                  if (too_long) begin
                     phase_in     = PH_HUNT_FIRST;
                     crc_in       = CRC_INIT;
                     version_in   = '0;
                     flags_in     = '0;
                     type_in      = '0;
                     length_in    = '0;
                     sequence_in  = '0;
                     timestamp_in = '0;
                     crc_low_in   = '0;
                  end
               end
            end
            PH_BODY: begin
               if (count_wide < length_ff) begin
                  crc_in   = crc_upd;
                  count_in = count_ff + 1'b1;
               end else if (count_wide == length_ff) begin
                  crc_low_in = rx_byte;
                  count_in   = count_ff + 1'b1;
               end else begin
                  phase_in     = PH_HUNT_FIRST;
                  count_in     = '0;
                  crc_in       = CRC_INIT;
                  version_in   = '0;
                  flags_in     = '0;
                  type_in      = '0;
                  length_in    = '0;
                  sequence_in  = '0;
                  timestamp_in = '0;
                  crc_low_in   = '0;
               end
            end
            default: phase_in = PH_HUNT_FIRST;
         endcase
      end
   end

   // result for the item at hand
   always_comb begin
      result = '0;
      case (phase_ff)
         PH_HEADER: begin
            if (hdr_last && too_long) result.status = ST_OVERFLOW;
         end
         PH_BODY: begin
            if (count_wide < length_ff) begin
               result.status       = ST_PAYLOAD;
               result.payload_byte = rx_byte;
            end else if (count_wide != length_ff) begin
               if (rx_crc == crc_ff) begin
                  result.status         = ST_READY;
                  result.version        = version_ff;
                  result.flags          = flags_ff;
                  result.packet_type    = type_ff;
                  result.payload_length = length_ff[8:0];
                  result.sequence_res   = sequence_ff;
                  result.timestamp_ms   = timestamp_ff;
                  result.received_crc   = rx_crc;
               end else begin
                  result.status = ST_CRCERR;
               end
            end
         end
         default: result.status = ST_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_FIRST;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= '0;
         flags_ff     <= '0;
         type_ff      <= '0;
         length_ff    <= '0;
         sequence_ff  <= '0;
         timestamp_ff <= '0;
         crc_low_ff   <= '0;
      end else begin
         version_ff   <= version_in;
         flags_ff     <= flags_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         sequence_ff  <= sequence_in;
         timestamp_ff <= timestamp_in;
         crc_low_ff   <= crc_low_in;
      end
   end

endmodule

// ----- rtl/core/sync_frame_deframer_crc16.sv -----
// path: an accepted byte waits in the input register, then its result in the result
// register, which holds the result until rsp_ready takes it
// throughput: one byte per cycle while results are taken; the crc update is an 8-step xor chain per byte
// reset: synchronous, active high; returns to the first-sync hunt, crc to ffff,
// sync bytes to aa and 55, both pipeline registers empty
`timescale 1ns / 1ps

`include "sync_frame_deframer_crc16_assert.svh"

module sync_frame_deframer_crc16 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_payload_byte,
   output logic [7:0]                     rsp_version,
   output logic [7:0]                     rsp_flags,
   output logic [7:0]                     rsp_packet_type,
   output logic [8:0]                     rsp_payload_length,
   output logic [31:0]                    rsp_sequence_res,
   output logic [31:0]                    rsp_timestamp_ms,
   output logic [15:0]                    rsp_received_crc,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sfdc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       stage_vld_ff, stage_vld_in;
   logic [7:0] stage_byte_ff, stage_byte_in;
   logic       rsp_vld_ff, rsp_vld_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    result;
   logic       advance;
   logic       csr_wr;
   logic       reg_sel;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_SYNC_FIRST:  cfg_in.sync_first = csr_pwdata[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SYNC_FIRST:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.sync_first};
         REG_SYNC_SECOND: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, cfg_ff.sync_second};
         default:         csr_prdata = '0;
      endcase
   end

   // input register, result register
   assign advance   = stage_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~stage_vld_ff | advance;

   assign stage_vld_in  = (req_valid & req_ready) | (stage_vld_ff & ~advance);
   assign stage_byte_in = (req_valid & req_ready) ? req_rx_byte : stage_byte_ff;
   assign rsp_vld_in    = advance | (rsp_vld_ff & ~rsp_ready);
   assign rsp_in        = advance ? result : rsp_ff;

   sfdc_frame_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (stage_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RST;
         cfg_ff.sync_second <= SYNC_SECOND_RST;
         stage_vld_ff       <= 1'b0;
         rsp_vld_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_version        = rsp_ff.version;
   assign rsp_flags          = rsp_ff.flags;
   assign rsp_packet_type    = rsp_ff.packet_type;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_sequence_res   = rsp_ff.sequence_res;
   assign rsp_timestamp_ms   = rsp_ff.timestamp_ms;
   assign rsp_received_crc   = rsp_ff.received_crc;

   `SFDC_ASSERT_NEXT(a_stage_holds, stage_vld_ff && rsp_vld_ff && !rsp_ready,
      stage_vld_ff && $stable(stage_byte_ff), "input register lost an item while blocked")
   `SFDC_ASSERT_NEXT(a_advance_fills, advance, rsp_vld_ff, "result register not filled")
   `SFDC_ASSERT_NOW(a_payload_zero, rsp_vld_ff && rsp_ff.status != ST_PAYLOAD,
      rsp_ff.payload_byte == 8'd0, "payload byte set outside a payload item")
   `SFDC_ASSERT_NOW(a_header_zero, rsp_vld_ff && rsp_ff.status != ST_READY,
      rsp_ff.sequence_res == 32'd0 && rsp_ff.received_crc == 16'd0,
      "header fields set outside frame ready")

endmodule

// ----- verif/sync_frame_deframer_crc16_tb.sv -----
`timescale 1ns / 1ps

module sync_frame_deframer_crc16_tb;
   import sfdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 40;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SYNC_FIRST  = {REG_SYNC_FIRST, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SYNC_SECOND = {REG_SYNC_SECOND, 2'b00};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [7:0]            rsp_payload_byte;
   logic [7:0]            rsp_version;
   logic [7:0]            rsp_flags;
   logic [7:0]            rsp_packet_type;
   logic [8:0]            rsp_payload_length;
   logic [31:0]           rsp_sequence_res;
   logic [31:0]           rsp_timestamp_ms;
   logic [15:0]           rsp_received_crc;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [7:0] rx_stream[$];
   rsp_type    predicted_out[$];
   int         queued_count = 0;
   int         mismatch_count = 0;
   int         idle_cycles = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_fire = 1'b0;

   // deframer state kept by the testbench
   logic [7:0]  sync_first_cfg = SYNC_FIRST_RST;
   logic [7:0]  sync_second_cfg = SYNC_SECOND_RST;
   phase_type   frame_phase;
   logic [8:0]  byte_count;
   logic [15:0] frame_crc;
   logic [7:0]  hdr_version;
   logic [7:0]  hdr_flags;
   logic [7:0]  hdr_type;
   logic [15:0] hdr_length;
   logic [31:0] hdr_sequence;
   logic [31:0] hdr_timestamp;
   logic [7:0]  crc_low;

   sync_frame_deframer_crc16 DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_version        (rsp_version),
      .rsp_flags          (rsp_flags),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_timestamp_ms   (rsp_timestamp_ms),
      .rsp_received_crc   (rsp_received_crc),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bit-serial form of the ccitt update
   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_phase = PH_HUNT_FIRST;
      byte_count = '0;
      frame_crc = CRC_INIT;
      hdr_version = '0;
      hdr_flags = '0;
      hdr_type = '0;
      hdr_length = '0;
      hdr_sequence = '0;
      hdr_timestamp = '0;
      crc_low = '0;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.status = ST_NONE;
      case (frame_phase)
         PH_HUNT_FIRST: begin
            if (b == sync_first_cfg) frame_phase = PH_HUNT_SECOND;
         end
         PH_HUNT_SECOND: begin
            if (b == sync_second_cfg) begin
               frame_phase = PH_HEADER;
               byte_count = '0;
               frame_crc = CRC_INIT;
            end else if (b != sync_first_cfg) begin
               frame_phase = PH_HUNT_FIRST;
            end
         end
         PH_HEADER: begin
            frame_crc = crc_ccitt_step(frame_crc, b);
            case (byte_count)
               0: hdr_version = b;
               1: hdr_flags = b;
               2: hdr_type = b;
               3: hdr_length[7:0] = b;
               4: hdr_length[15:8] = b;
               5, 6, 7, 8: hdr_sequence[8*(byte_count-5) +: 8] = b;
               default: hdr_timestamp[8*(byte_count-9) +: 8] = b;
            endcase
            if (byte_count == HDR_LAST) begin
               if (hdr_length > MAX_PAYLOAD) begin
                  clear_frame();
                  r.status = ST_OVERFLOW;
               end else begin
                  frame_phase = PH_BODY;
                  byte_count = '0;
               end
            end else begin
               byte_count++;
            end
         end
         default: begin
            if (byte_count < hdr_length) begin
               frame_crc = crc_ccitt_step(frame_crc, b);
               byte_count++;
               r.status = ST_PAYLOAD;
               r.payload_byte = b;
            end else if (byte_count == hdr_length) begin
               crc_low = b;
               byte_count++;
            end else begin
               if ({b, crc_low} == frame_crc) begin
                  r.status = ST_READY;
                  r.version = hdr_version;
                  r.flags = hdr_flags;
                  r.packet_type = hdr_type;
                  r.payload_length = hdr_length[8:0];
                  r.sequence_res = hdr_sequence;
                  r.timestamp_ms = hdr_timestamp;
                  r.received_crc = {b, crc_low};
               end else begin
                  r.status = ST_CRCERR;
               end
               clear_frame();
            end
         end
      endcase
      predicted_out.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (predicted_out.size() == 0) begin
         report_mismatch("result with no item pending");
      end else begin
         want = predicted_out.pop_front();
         check_field("status", 32'(rsp_status), 32'(want.status));
         check_field("payload_byte", 32'(rsp_payload_byte), 32'(want.payload_byte));
         check_field("version", 32'(rsp_version), 32'(want.version));
         check_field("flags", 32'(rsp_flags), 32'(want.flags));
         check_field("packet_type", 32'(rsp_packet_type), 32'(want.packet_type));
         check_field("payload_length", 32'(rsp_payload_length),
                     32'(want.payload_length));
         check_field("sequence_res", rsp_sequence_res, want.sequence_res);
         check_field("timestamp_ms", rsp_timestamp_ms, want.timestamp_ms);
         check_field("received_crc", 32'(rsp_received_crc), 32'(want.received_crc));
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) check_result();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {{(CSR_DATA_W-8){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_sync_bytes(input logic [7:0] first, input logic [7:0] second);
      csr_write(ADDR_SYNC_FIRST, first);
      csr_write(ADDR_SYNC_SECOND, second);
      sync_first_cfg = first;
      sync_second_cfg = second;
   endtask

   task automatic wait_drained();
      while (rx_stream.size() != 0 || req_valid || predicted_out.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      rx_stream.push_back(b);
      queued_count++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_frame(input logic [15:0] len, input bit bad_crc, input bit extra_first);
      logic [7:0]  hdr[13];
      logic [7:0]  b;
      logic [15:0] crc;
      logic [31:0] seq;
      logic [31:0] stamp;
      seq = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
      stamp = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
      hdr[0] = pick_byte();
      hdr[1] = pick_byte();
      hdr[2] = pick_byte();
      hdr[3] = len[7:0];
      hdr[4] = len[15:8];
      for (int i = 0; i < 4; i++) begin
         hdr[5+i] = seq[8*i +: 8];
         hdr[9+i] = stamp[8*i +: 8];
      end
      if (extra_first) queue_byte(sync_first_cfg);
      queue_byte(sync_first_cfg);
      queue_byte(sync_second_cfg);
      crc = CRC_INIT;
      for (int i = 0; i < 13; i++) begin
         queue_byte(hdr[i]);
         crc = crc_ccitt_step(crc, hdr[i]);
      end
      if (len <= MAX_PAYLOAD) begin
         for (int i = 0; i < len; i++) begin
            b = pick_byte();
            queue_byte(b);
            crc = crc_ccitt_step(crc, b);
         end
         if (bad_crc) crc = crc ^ (16'h1 << $urandom_range(0, 15));
         queue_byte(crc[7:0]);
         queue_byte(crc[15:8]);
      end
   endtask

   task automatic fill_random(input int n_bytes);
      int          start;
      int          r;
      int          l;
      logic [15:0] len;
      start = queued_count;
      while (queued_count - start < n_bytes) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
         end else if (r < 16) begin
            // broken sync sequence
            queue_byte(sync_first_cfg);
            if ($urandom_range(0, 1)) queue_byte(sync_first_cfg);
            queue_byte(8'($urandom_range(0, 255)));
         end else begin
            l = $urandom_range(0, 99);
            if (l < 3) len = MAX_PAYLOAD;
            else if (l < 5) len = 16'(MAX_PAYLOAD - 1);
            else if (l < 8) len = 16'(MAX_PAYLOAD + 1);
            else if (l < 10) len = 16'hFFFF;
            else if (l < 13) len = 16'($urandom_range(MAX_PAYLOAD + 2, 16'hFFFE));
            else len = 16'($urandom_range(0, 24));
            queue_frame(len, $urandom_range(0, 99) < 15,
                        sync_first_cfg != sync_second_cfg && $urandom_range(0, 9) == 0);
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                            input int send_pct, input int recv_pct);
      wait_drained();
      set_sync_bytes(first, second);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      fill_random(380);
   endtask

   initial begin
      clear_frame();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_sync_bytes(SYNC_FIRST_RST, SYNC_SECOND_RST);
      // noise, wrong second sync, repeated first sync, empty frame
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(sync_first_cfg);
      queue_byte(8'h12);
      queue_frame(16'h0000, 1'b0, 1'b1);
      fill_random(360);
      run_phase(8'h00, 8'hFF, 49, 0);
      run_phase(8'hFF, 8'h00, 0, 49);
      run_phase(8'h5A, 8'h5A, 19, 19);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 19, 19);
      wait_drained();
      repeat (8) @(negedge clock);
      if (predicted_out.size() != 0) report_mismatch("results never delivered");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sfdc_pkg.sv
rtl/core/sfdc_frame_fsm.sv
rtl/core/sync_frame_deframer_crc16.sv
verif/sync_frame_deframer_crc16_tb.sv
